### src/dpd_pkg.sv
package dpd_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    K_SIZE = 3'd0,
    K_LIT  = 3'd1,
    K_COPY = 3'd2,
    K_CSOK = 3'd3,
    K_ERR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    E_NO_NEWLINE = 2'd0,
    E_NO_COMMA   = 2'd1,
    E_CHECKSUM   = 2'd2,
    E_UNKNOWN    = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    PH_SIZE    = 5'b00001,
    PH_CMD     = 5'b00010,
    PH_OFFSET  = 5'b00100,
    PH_LITERAL = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       is_digit;
    logic [5:0] value;
  } digit_t;

endpackage

### src/dpd_if.sv
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output op, output data_byte, output last, input ready);
  modport sink   (input valid, input op, input data_byte, input last, output ready);
endinterface

interface dpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] copy_offset;
  logic [31:0] copy_length;
  logic [31:0] target_size;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output out_byte, output copy_offset,
                  output copy_length, output target_size, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input copy_offset,
                  input copy_length, input target_size, input error_code,
                  output ready);
endinterface

### src/delta_patch_decoder_unit.sv
// Path: a request accepted at the input passes through the input register, then
//   the combinational parse logic into the result register.
// Throughput: one request per cycle, set by the combinational parse step; only a
//   stalled result register holds the input side back.
// Reset: synchronous active-low rst_n returns the parser to reading the size
//   header with cleared number, checksum and lane state; both stages go empty.
module delta_patch_decoder_unit #(
  parameter int NUMBER_WIDTH = dpd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dpd_in_if.sink    in_ch,
  dpd_out_if.source out_ch
);

  dpd_pkg::in_item_t in_item;
  dpd_pkg::in_item_t s1_item;
  dpd_pkg::digit_t   digit;
  logic              s1_valid;
  logic              take;
  logic              out_valid;

  assign in_item.op        = in_ch.op;
  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last      = in_ch.last;

  // Stage 1 request is consumed whenever the result register can take a new
  // value; requests that produce no result still move on in that cycle.
  assign take = s1_valid && (!out_valid || out_ch.ready);

  dpd_input_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_ch.ready),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  // base-64 digit classification of the registered byte
  dpd_digit u_digit (
    .byte_i  (s1_item.data_byte),
    .digit_o (digit)
  );

  // phase machine, number accumulator, checksum and result register
  dpd_parser #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .work_i        (take),
    .item_i        (s1_item),
    .digit_i       (digit),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_valid),
    .kind_o        (out_ch.kind),
    .out_byte_o    (out_ch.out_byte),
    .copy_offset_o (out_ch.copy_offset),
    .copy_length_o (out_ch.copy_length),
    .target_size_o (out_ch.target_size),
    .error_code_o  (out_ch.error_code)
  );

  assign out_ch.valid = out_valid;

endmodule

### src/dpd_input_stage.sv
module dpd_input_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  input  dpd_pkg::in_item_t in_item_i,
  output logic             in_ready_o,
  input  logic             take_i,
  output logic             s1_valid_o,
  output dpd_pkg::in_item_t s1_item_o
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  dpd_pkg::in_item_t s1_item_r;
  logic              in_fire;

  // slot frees up in the same cycle the parser consumes it
  assign in_ready_o   = !s1_valid_r || take_i;
  assign in_fire      = in_valid_i && in_ready_o;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item_i;
    end
  end

  assign s1_valid_o = s1_valid_r;
  assign s1_item_o  = s1_item_r;

endmodule

### src/dpd_digit.sv
module dpd_digit (
  input  logic [7:0]      byte_i,
  output dpd_pkg::digit_t digit_o
);

  localparam logic [7:0] OFS_NUM   = 8'd48;
  localparam logic [7:0] OFS_UPPER = 8'd55;
  localparam logic [7:0] OFS_LOWER = 8'd60;
  localparam logic [5:0] VAL_UNDER = 6'd36;
  localparam logic [5:0] VAL_TILDE = 6'd63;

  logic [7:0] diff;

  always_comb begin
    digit_o.is_digit = 1'b1;
    diff             = 8'd0;
    digit_o.value    = 6'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      diff          = byte_i - OFS_NUM;
      digit_o.value = diff[5:0];
    end else if (byte_i >= 8'h41 && byte_i <= 8'h5A) begin
      diff          = byte_i - OFS_UPPER;
      digit_o.value = diff[5:0];
    end else if (byte_i >= 8'h61 && byte_i <= 8'h7A) begin
      diff          = byte_i - OFS_LOWER;
      digit_o.value = diff[5:0];
    end else if (byte_i == 8'h5F) begin
      digit_o.value = VAL_UNDER;
    end else if (byte_i == 8'h7E) begin
      digit_o.value = VAL_TILDE;
    end else begin
      digit_o.is_digit = 1'b0;
    end
  end

endmodule

### src/dpd_parser.sv
module dpd_parser #(
  parameter int NUMBER_WIDTH = dpd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              work_i,
  input  dpd_pkg::in_item_t item_i,
  input  dpd_pkg::digit_t   digit_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [2:0]        kind_o,
  output logic [7:0]        out_byte_o,
  output logic [31:0]       copy_offset_o,
  output logic [31:0]       copy_length_o,
  output logic [31:0]       target_size_o,
  output logic [1:0]        error_code_o
);

  // compare / output width covers both the number and the 32-bit sum
  localparam int CW = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

  dpd_pkg::phase_t   phase_r, phase_nxt;
  logic [NUMBER_WIDTH-1:0] accum_r, accum_nxt;
  logic [NUMBER_WIDTH-1:0] count_r, count_nxt;
  logic [NUMBER_WIDTH-1:0] lit_left_r, lit_left_nxt;
  logic [31:0]       sum_r, sum_nxt;
  logic [1:0]        lane_r, lane_nxt;

  logic              out_valid_r, out_valid_nxt;
  dpd_pkg::kind_t    kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic [31:0]       length_r, length_nxt;
  logic [31:0]       size_r, size_nxt;
  dpd_pkg::err_t     err_r, err_nxt;

  logic              res_valid;
  logic [NUMBER_WIDTH-1:0] accum_shift;
  logic [NUMBER_WIDTH-1:0] lit_dec;
  logic [CW-1:0]     accum_ext;
  logic [CW-1:0]     count_ext;
  logic [CW-1:0]     sum_ext;
  logic [31:0]       sum_add;

  assign accum_shift = {accum_r[NUMBER_WIDTH-7:0], 6'b0} + NUMBER_WIDTH'(digit_i.value);
  assign lit_dec     = lit_left_r - NUMBER_WIDTH'(1);
  assign accum_ext   = CW'(accum_r);
  assign count_ext   = CW'(count_r);
  assign sum_ext     = CW'(sum_r);

  // big-endian lane placement of the byte into the checksum word
  always_comb begin
    case (lane_r)
      2'd0:    sum_add = {item_i.data_byte, 24'd0};
      2'd1:    sum_add = {8'd0, item_i.data_byte, 16'd0};
      2'd2:    sum_add = {16'd0, item_i.data_byte, 8'd0};
      default: sum_add = {24'd0, item_i.data_byte};
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    accum_nxt    = accum_r;
    count_nxt    = count_r;
    lit_left_nxt = lit_left_r;
    sum_nxt      = sum_r;
    lane_nxt     = lane_r;
    res_valid    = 1'b0;
    kind_nxt     = dpd_pkg::K_SIZE;
    byte_nxt     = 8'd0;
    offset_nxt   = 32'd0;
    length_nxt   = 32'd0;
    size_nxt     = 32'd0;
    err_nxt      = dpd_pkg::E_NO_NEWLINE;

    if (work_i && phase_r != dpd_pkg::PH_DONE) begin
      if (item_i.op) begin
        sum_nxt  = sum_r + sum_add;
        lane_nxt = lane_r + 2'd1;
      end else begin
        case (phase_r)
          dpd_pkg::PH_SIZE: begin
            if (digit_i.is_digit) begin
              accum_nxt = accum_shift;
            end else if (item_i.data_byte == dpd_pkg::CH_NEWLINE) begin
              accum_nxt = '0;
              phase_nxt = dpd_pkg::PH_CMD;
              res_valid = 1'b1;
              kind_nxt  = dpd_pkg::K_SIZE;
              size_nxt  = accum_ext[31:0];
            end else begin
              phase_nxt = dpd_pkg::PH_DONE;
              res_valid = 1'b1;
              kind_nxt  = dpd_pkg::K_ERR;
              err_nxt   = dpd_pkg::E_NO_NEWLINE;
            end
          end
          dpd_pkg::PH_CMD: begin
            if (digit_i.is_digit) begin
              accum_nxt = accum_shift;
            end else if (item_i.data_byte == dpd_pkg::CH_AT) begin
              count_nxt = accum_r;
              accum_nxt = '0;
              phase_nxt = dpd_pkg::PH_OFFSET;
            end else if (item_i.data_byte == dpd_pkg::CH_COLON) begin
              lit_left_nxt = accum_r;
              accum_nxt    = '0;
              // zero-length literal stays in command phase
              phase_nxt    = (accum_r != '0) ? dpd_pkg::PH_LITERAL : dpd_pkg::PH_CMD;
            end else if (item_i.data_byte == dpd_pkg::CH_SEMI) begin
              phase_nxt = dpd_pkg::PH_DONE;
              res_valid = 1'b1;
              if (accum_ext == sum_ext) begin
                kind_nxt = dpd_pkg::K_CSOK;
              end else begin
                kind_nxt = dpd_pkg::K_ERR;
                err_nxt  = dpd_pkg::E_CHECKSUM;
              end
            end else begin
              phase_nxt = dpd_pkg::PH_DONE;
              res_valid = 1'b1;
              kind_nxt  = dpd_pkg::K_ERR;
              err_nxt   = dpd_pkg::E_UNKNOWN;
            end
          end
          dpd_pkg::PH_OFFSET: begin
            if (digit_i.is_digit) begin
              accum_nxt = accum_shift;
            end else if (item_i.data_byte == dpd_pkg::CH_COMMA) begin
              res_valid  = 1'b1;
              kind_nxt   = dpd_pkg::K_COPY;
              offset_nxt = accum_ext[31:0];
              length_nxt = count_ext[31:0];
              accum_nxt  = '0;
              phase_nxt  = dpd_pkg::PH_CMD;
            end else begin
              phase_nxt = dpd_pkg::PH_DONE;
              res_valid = 1'b1;
              kind_nxt  = dpd_pkg::K_ERR;
              err_nxt   = dpd_pkg::E_NO_COMMA;
            end
          end
          dpd_pkg::PH_LITERAL: begin
            sum_nxt      = sum_r + sum_add;
            lane_nxt     = lane_r + 2'd1;
            lit_left_nxt = lit_dec;
            if (lit_dec == '0) begin
              phase_nxt = dpd_pkg::PH_CMD;
            end
            res_valid = 1'b1;
            kind_nxt  = dpd_pkg::K_LIT;
            byte_nxt  = item_i.data_byte;
          end
          default: begin
            phase_nxt = dpd_pkg::PH_DONE;
          end
        endcase
        if (item_i.last) begin
          phase_nxt = dpd_pkg::PH_DONE;
        end
      end
    end
  end

  always_comb begin
    if (work_i && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dpd_pkg::PH_SIZE;
      accum_r     <= '0;
      count_r     <= '0;
      lit_left_r  <= '0;
      sum_r       <= 32'd0;
      lane_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      count_r     <= count_nxt;
      lit_left_r  <= lit_left_nxt;
      sum_r       <= sum_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (work_i && res_valid) begin
      kind_r   <= kind_nxt;
      byte_r   <= byte_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      size_r   <= size_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_valid_o   = out_valid_r;
  assign kind_o        = kind_r;
  assign out_byte_o    = byte_r;
  assign copy_offset_o = offset_r;
  assign copy_length_o = length_r;
  assign target_size_o = size_r;
  assign error_code_o  = err_r;

  // closed parser never loads a new result
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dpd_pkg::PH_DONE && !(out_valid_r && !out_ready_i)) |=> !out_valid_r)
    else $error("result produced after parser closed");

  // a literal-phase stream byte always yields a literal result
  a_lit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (work_i && phase_r == dpd_pkg::PH_LITERAL && !item_i.op)
      |=> (out_valid_r && kind_r == dpd_pkg::K_LIT))
    else $error("literal byte not forwarded");

  // terminal results leave the parser closed
  a_term_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == dpd_pkg::K_ERR || kind_r == dpd_pkg::K_CSOK))
      |-> phase_r == dpd_pkg::PH_DONE)
    else $error("parser open after terminal result");

endmodule
